// ===== design/rbf_pkg.sv =====
// Shared constants, codes and control types for the ring buffer FIFO.
package rbf_pkg;

   localparam int RBF_DEPTH      = 256;
   localparam int RBF_ELEM_WIDTH = 8;
   localparam int RBF_MAX_BURST  = 64;

   localparam int RBF_CMD_W   = 2;
   localparam int RBF_BURST_W = 7;
   localparam int RBF_FILL_W  = 8;
   localparam int RBF_CSR_W   = 9;

   localparam logic [RBF_CSR_W-1:0] RBF_CAP_RESET = 9'd256;

   typedef enum logic [RBF_CMD_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_STATUS  = 2'd2
   } rbf_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } rbf_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic rd_en;
      logic rd_next;
      logic pop;
   } rbf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic deq_burst;
      logic cnt_last;
   } rbf_sts_type;

endpackage

// ===== design/rbf_if.sv =====
// Request and response channel interfaces of the ring buffer FIFO.
interface rbf_req_if
   import rbf_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [RBF_CMD_W-1:0]      command;
   logic [RBF_ELEM_WIDTH-1:0] data_in;
   logic [RBF_BURST_W-1:0]    burst_count;

   modport source (output valid, command, data_in, burst_count, input ready);
   modport sink   (input valid, command, data_in, burst_count, output ready);
endinterface

interface rbf_rsp_if
   import rbf_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [RBF_ELEM_WIDTH-1:0] data_out;
   logic                      ok;
   logic                      last;
   logic [RBF_FILL_W-1:0]     fill_level;
   logic                      is_empty;
   logic                      is_full;

   modport source (output valid, data_out, ok, last, fill_level, is_empty, is_full,
                   input ready);
   modport sink   (input valid, data_out, ok, last, fill_level, is_empty, is_full,
                   output ready);
endinterface

// ===== design/rbf_ctrl.sv =====
// Controller state machine: sequences accepts, memory reads and burst results.
module rbf_ctrl
   import rbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  rbf_sts_type sts,
   output rbf_cmd_type cmd
);

   rbf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.out_free && sts.deq_burst) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free && sts.cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.accept  = 1'b0;
      cmd.rd_en   = 1'b0;
      cmd.rd_next = 1'b0;
      cmd.pop     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = sts.out_free;
            cmd.accept = req_valid && sts.out_free;
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
         end
         ST_EMIT: begin
            // Each result taken, except the last of the burst, also fetches the element after it.
            cmd.pop     = sts.out_free;
            cmd.rd_next = 1'b1;
            cmd.rd_en   = sts.out_free && !sts.cnt_last;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== design/rbf_datapath.sv =====
// Datapath: slot memory, ring positions, burst counter and response register.
module rbf_datapath
   import rbf_pkg::*;
#(
   parameter int DEPTH      = RBF_DEPTH,
   parameter int MAX_BURST  = RBF_MAX_BURST
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [RBF_CSR_W-1:0]      csr_wdata,
   input  logic [RBF_CMD_W-1:0]      command,
   input  logic [RBF_ELEM_WIDTH-1:0] data_in,
   input  logic [RBF_BURST_W-1:0]    burst_count,
   input  logic                      rsp_ready,
   input  rbf_cmd_type               cmd,
   output rbf_sts_type               sts,
   output logic                      rsp_valid,
   output logic [RBF_ELEM_WIDTH-1:0] data_out,
   output logic                      ok,
   output logic                      last,
   output logic [RBF_FILL_W-1:0]     fill_level,
   output logic                      is_empty,
   output logic                      is_full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EW    = (CNT_W > RBF_CSR_W) ? CNT_W : RBF_CSR_W;
   localparam int FW    = (CNT_W > RBF_FILL_W) ? CNT_W : RBF_FILL_W;
   localparam int BW    = $clog2(MAX_BURST + 1);
   localparam int MW    = (CNT_W > RBF_BURST_W) ? CNT_W : RBF_BURST_W;

   function automatic logic [CNT_W-1:0] clamp_cap(input logic [RBF_CSR_W-1:0] v);
      logic [EW-1:0] ext;
      ext = EW'(v);
      if (ext < EW'(2)) begin
         return CNT_W'(2);
      end
      if (ext > EW'(DEPTH)) begin
         return CNT_W'(DEPTH);
      end
      return CNT_W'(ext);
   endfunction

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
      if ((CNT_W'(p) + CNT_W'(1)) == cap) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   // Positions are always below the capacity, so one conditional add covers the wrap.
   function automatic logic [CNT_W-1:0] fill_of(input logic [PTR_W-1:0] r,
                                                input logic [PTR_W-1:0] w,
                                                input logic [CNT_W-1:0] cap);
      if (w >= r) begin
         return CNT_W'(w) - CNT_W'(r);
      end
      return CNT_W'(w) + cap - CNT_W'(r);
   endfunction

   logic [RBF_ELEM_WIDTH-1:0] mem [DEPTH];
   logic [RBF_ELEM_WIDTH-1:0] rd_data_ff;

   logic [CNT_W-1:0] cap_ff;
   logic [PTR_W-1:0] rd_pos_ff, rd_pos_in;
   logic [PTR_W-1:0] wr_pos_ff, wr_pos_in;
   logic [BW-1:0]    cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [RBF_ELEM_WIDTH-1:0] data_out_ff, data_out_in;
   logic                      ok_ff, ok_in;
   logic                      last_ff, last_in;
   logic [RBF_FILL_W-1:0]     fill_ff, fill_in;
   logic                      empty_ff, empty_in;
   logic                      full_ff, full_in;

   logic             full_now;
   logic [CNT_W-1:0] avail;
   logic [MW-1:0]    want;
   logic [MW-1:0]    deq_n;
   logic             deq_burst;
   logic             enq_ok;
   logic             imm_load;
   logic             out_load;
   logic [PTR_W-1:0] rd_addr;
   logic [CNT_W-1:0] fill_nx;
   logic [FW-1:0]    fill_ext;

   always_comb begin
      full_now  = (wrap_inc(wr_pos_ff, cap_ff) == rd_pos_ff);
      avail     = fill_of(rd_pos_ff, wr_pos_ff, cap_ff);
      want      = (MW'(burst_count) > MW'(MAX_BURST)) ? MW'(MAX_BURST) : MW'(burst_count);
      deq_n     = (want < MW'(avail)) ? want : MW'(avail);
      deq_burst = (command == OP_DEQUEUE) && (deq_n != '0);
      enq_ok    = cmd.accept && (command == OP_ENQUEUE) && !full_now;
      imm_load  = cmd.accept && !deq_burst;
      out_load  = imm_load || cmd.pop;

      wr_pos_in = enq_ok ? wrap_inc(wr_pos_ff, cap_ff) : wr_pos_ff;
      rd_pos_in = cmd.pop ? wrap_inc(rd_pos_ff, cap_ff) : rd_pos_ff;
      rd_addr   = cmd.rd_next ? rd_pos_in : rd_pos_ff;

      cnt_in = cnt_ff;
      if (cmd.accept && deq_burst) begin
         cnt_in = BW'(deq_n);
      end else if (cmd.pop) begin
         cnt_in = cnt_ff - BW'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Status of every result is taken after the transaction's own update.
      fill_nx  = fill_of(rd_pos_in, wr_pos_in, cap_ff);
      fill_ext = FW'(fill_nx);
      fill_in  = fill_ext[RBF_FILL_W-1:0];
      empty_in = (rd_pos_in == wr_pos_in);
      full_in  = (wrap_inc(wr_pos_in, cap_ff) == rd_pos_in);

      if (cmd.pop) begin
         data_out_in = rd_data_ff;
         ok_in       = 1'b1;
         last_in     = (cnt_ff == BW'(1));
      end else begin
         data_out_in = '0;
         last_in     = 1'b1;
         case (command)
            OP_ENQUEUE: ok_in = !full_now;
            OP_STATUS:  ok_in = 1'b1;
            default:    ok_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= clamp_cap(RBF_CAP_RESET);
         rd_pos_ff    <= '0;
         wr_pos_ff    <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff    <= clamp_cap(csr_wdata);
            rd_pos_ff <= '0;
            wr_pos_ff <= '0;
         end else begin
            rd_pos_ff <= rd_pos_in;
            wr_pos_ff <= wr_pos_in;
         end
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq_ok) begin
         mem[wr_pos_ff] <= data_in;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         data_out_ff <= data_out_in;
         ok_ff       <= ok_in;
         last_ff     <= last_in;
         fill_ff     <= fill_in;
         empty_ff    <= empty_in;
         full_ff     <= full_in;
      end
   end

   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign sts.deq_burst = deq_burst;
   assign sts.cnt_last  = (cnt_ff == BW'(1));

   assign rsp_valid  = rsp_valid_ff;
   assign data_out   = data_out_ff;
   assign ok         = ok_ff;
   assign last       = last_ff;
   assign fill_level = fill_ff;
   assign is_empty   = empty_ff;
   assign is_full    = full_ff;

endmodule

// ===== design/ring_buffer_fifo.sv =====
// Top level of the ring buffer FIFO: controller, datapath and channel wiring.
//
//   channel   dir   handshake            contents
//   req_if    in    valid/ready          command, data_in, burst_count
//   rsp_if    out   valid/ready          data_out, ok, last, fill_level, is_empty, is_full
//   csr       in    csr_we (no stall)    capacity (9 bits)
//
// Enqueue, status and empty dequeues are accepted and the result sits in the output register
// on the next cycle. A dequeue burst of n elements passes an accept step, the registered read
// of the slot memory, then one element per cycle while the output register is free.
// Reset clears the positions and sets capacity 256; the slot memory is not cleared.
// While rsp_if.ready is low the output register holds and a running burst pauses.
module ring_buffer_fifo
   import rbf_pkg::*;
#(
   parameter int DEPTH      = RBF_DEPTH,
   parameter int MAX_BURST  = RBF_MAX_BURST
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [RBF_CSR_W-1:0] csr_wdata,
   rbf_req_if.sink              req_if,
   rbf_rsp_if.source            rsp_if
);

   rbf_cmd_type cmd;
   rbf_sts_type sts;

   rbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rbf_datapath #(
      .DEPTH      (DEPTH),
      .MAX_BURST  (MAX_BURST)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .command     (req_if.command),
      .data_in     (req_if.data_in),
      .burst_count (req_if.burst_count),
      .rsp_ready   (rsp_if.ready),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_if.valid),
      .data_out    (rsp_if.data_out),
      .ok          (rsp_if.ok),
      .last        (rsp_if.last),
      .fill_level  (rsp_if.fill_level),
      .is_empty    (rsp_if.is_empty),
      .is_full     (rsp_if.is_full)
   );

   // A request transaction never overwrites a response that is still waiting.
   a_accept_needs_room: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |-> (!rsp_if.valid || rsp_if.ready))
      else $error("request accepted while the response register is blocked");

   // A burst element is only pushed into a free response register.
   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> sts.out_free)
      else $error("burst element loaded into a blocked response register");

   // No new request is taken in the cycle after a memory read was issued.
   a_no_accept_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> !(req_if.valid && req_if.ready))
      else $error("request accepted in the middle of a burst");

   // Accepts and burst pops are mutually exclusive.
   a_accept_pop_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.pop))
      else $error("accept and burst pop in the same cycle");

endmodule
